### design/vtl_pkg.sv
// Shared types and constants for the visitor table with least-frequently-used replacement.
// Used by the table unit, by its port checker and by the testbench. It depends on nothing else.
package vtl_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;
    localparam int SLOT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // One table record as it is held in the entry memory
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               auth;
    } entry_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

endpackage

### design/visitor_table_lfu_unit.sv
// Visitor table unit: entry memory, sequential scan for hit, empty and least-count entries,
// and read-modify-write of the chosen entry. Depends on vtl_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------------
//  input    | in_valid, in_stall  | client_address, counts_as_visit, password_accepted
//  output   | out_valid, out_stall| slot, was_known, visits, authorized, total_requests
//
// An item goes from acceptance through a scan and a decide step to its result: the scan
// reads one entry a cycle through the single read port of the entry memory, then the decide
// state chooses the entry, writes it back and loads the output register.
// Reset clears the valid bits at once; an entry that was never written reads as empty, so
// no clearing pass is needed and the unit takes items right after reset.
// A stalled result holds the choose-and-write step; input is taken only while idle.
module visitor_table_lfu_unit
    import vtl_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ADDR_W-1:0]  client_address,
    input  logic               counts_as_visit,
    input  logic               password_accepted,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SLOT_W-1:0]  slot,
    output logic               was_known,
    output logic [COUNT_W-1:0] visits,
    output logic               authorized,
    output logic [TOTAL_W-1:0] total_requests
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Entry memory and its valid bits
    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    // Sequencer
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               rd_en;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    // Captured request
    logic [ADDR_W-1:0]  req_addr_reg, req_addr_next;
    logic               req_counted_reg, req_counted_next;
    logic               req_pass_reg, req_pass_next;

    // Scan results
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic               hit_auth_reg, hit_auth_next;
    logic               have_empty_reg, have_empty_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic               have_used_reg, have_used_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [COUNT_W-1:0] min_cnt_reg, min_cnt_next;

    logic [TOTAL_W-1:0] total_reg, total_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               was_known_reg, was_known_next;
    logic [COUNT_W-1:0] visits_reg, visits_next;
    logic               authorized_reg, authorized_next;
    logic [TOTAL_W-1:0] total_out_reg, total_out_next;

    // Combinational helpers
    logic               in_accept;
    logic               out_free;
    logic               wr_en;
    logic [IDX_W-1:0]   sel_idx;
    logic [COUNT_W-1:0] base_cnt;
    logic               base_auth;
    logic [COUNT_W-1:0] new_cnt;
    logic               new_auth;
    logic [TOTAL_W-1:0] new_total;
    logic [COUNT_W-1:0] cur_cnt;
    logic               cur_used;
    entry_t             wr_entry;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_en     = (state_reg == ST_SCAN) && !issue_done_reg;

    // An entry never written reads as empty
    assign cur_cnt  = rd_valid_reg ? rd_data_reg.count : '0;
    assign cur_used = (cur_cnt != '0);

    // Choose the entry: hit first, then highest empty, then lowest least-count
    always_comb
    begin
        if (found_reg)
        begin
            sel_idx   = hit_idx_reg;
            base_cnt  = hit_cnt_reg;
            base_auth = hit_auth_reg;
        end
        else
        begin
            sel_idx   = have_empty_reg ? empty_idx_reg : min_idx_reg;
            base_cnt  = COUNT_ONE;
            base_auth = 1'b0;
        end
        new_cnt   = (req_counted_reg && base_cnt != COUNT_MAX) ? base_cnt + COUNT_ONE
                                                                : base_cnt;
        new_total = (req_counted_reg && total_reg != TOTAL_MAX) ? total_reg + TOTAL_W'(1)
                                                                 : total_reg;
        new_auth  = base_auth || req_pass_reg;
        wr_entry.addr  = req_addr_reg;
        wr_entry.count = new_cnt;
        wr_entry.auth  = new_auth;
    end

    assign wr_en = (state_reg == ST_DECIDE) && out_free;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        issue_done_next  = issue_done_reg;
        req_addr_next    = req_addr_reg;
        req_counted_next = req_counted_reg;
        req_pass_next    = req_pass_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        hit_auth_next    = hit_auth_reg;
        have_empty_next  = have_empty_reg;
        empty_idx_next   = empty_idx_reg;
        have_used_next   = have_used_reg;
        min_idx_next     = min_idx_reg;
        min_cnt_next     = min_cnt_reg;
        total_next       = total_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg && out_stall;
        slot_next        = slot_reg;
        was_known_next   = was_known_reg;
        visits_next      = visits_reg;
        authorized_next  = authorized_reg;
        total_out_next   = total_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the request and clear the scan results
                if (in_accept)
                begin
                    req_addr_next    = client_address;
                    req_counted_next = counts_as_visit;
                    req_pass_next    = password_accepted;
                    scan_idx_next    = '0;
                    issue_done_next  = 1'b0;
                    found_next       = 1'b0;
                    have_empty_next  = 1'b0;
                    have_used_next   = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Advance the read address
                if (rd_en)
                begin
                    if (scan_idx_reg == LAST_IDX)
                        issue_done_next = 1'b1;
                    else
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                // Examine the entry read in the previous cycle
                if (cmp_vld_reg)
                begin
                    if (cur_used && rd_data_reg.addr == req_addr_reg && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_cnt_next  = cur_cnt;
                        hit_auth_next = rd_data_reg.auth;
                    end
                    if (!cur_used)
                    begin
                        have_empty_next = 1'b1;
                        empty_idx_next  = cmp_idx_reg;
                    end
                    else if (!have_used_reg || cur_cnt < min_cnt_reg)
                    begin
                        have_used_next = 1'b1;
                        min_idx_next   = cmp_idx_reg;
                        min_cnt_next   = cur_cnt;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // Write back and load the result once the output register is free
                if (wr_en)
                begin
                    valid_next[sel_idx] = 1'b1;
                    total_next          = new_total;
                    out_valid_next      = 1'b1;
                    slot_next           = SLOT_W'(sel_idx);
                    was_known_next      = found_reg;
                    visits_next         = new_cnt;
                    authorized_next     = new_auth;
                    total_out_next      = new_total;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issue_done_reg  <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            have_empty_reg  <= 1'b0;
            have_used_reg   <= 1'b0;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_done_reg  <= issue_done_next;
            cmp_vld_reg     <= rd_en;
            found_reg       <= found_next;
            have_empty_reg  <= have_empty_next;
            have_used_reg   <= have_used_next;
            valid_reg       <= valid_next;
            rd_valid_reg    <= valid_reg[scan_idx_reg];
            total_reg       <= total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= scan_idx_reg;
        req_addr_reg    <= req_addr_next;
        req_counted_reg <= req_counted_next;
        req_pass_reg    <= req_pass_next;
        hit_idx_reg     <= hit_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        hit_auth_reg    <= hit_auth_next;
        empty_idx_reg   <= empty_idx_next;
        min_idx_reg     <= min_idx_next;
        min_cnt_reg     <= min_cnt_next;
        slot_reg        <= slot_next;
        was_known_reg   <= was_known_next;
        visits_reg      <= visits_next;
        authorized_reg  <= authorized_next;
        total_out_reg   <= total_out_next;
    end

    // Entry memory: one read and one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[scan_idx_reg];
        if (wr_en)
            mem[sel_idx] <= wr_entry;
    end

    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign was_known      = was_known_reg;
    assign visits         = visits_reg;
    assign authorized     = authorized_reg;
    assign total_requests = total_out_reg;

endmodule

### design/vtl_checker.sv
// Port checker for the visitor table unit, bound into every instance of visitor_table_lfu_unit.
// Depends on vtl_pkg and on the port names of visitor_table_lfu_unit.
module vtl_checker
    import vtl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [SLOT_W-1:0]  slot,
    input logic               was_known,
    input logic [COUNT_W-1:0] visits,
    input logic               authorized,
    input logic [TOTAL_W-1:0] total_requests
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(visits)
            && $stable(was_known) && $stable(authorized) && $stable(total_requests))
        else $error("stalled result changed");

    // A reported entry is always in use
    a_visits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> visits != '0)
        else $error("result reports an empty entry");

    // A new entry starts at one visit, two if the item was counted
    a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_known |-> visits == COUNT_W'(1) || visits == COUNT_W'(2))
        else $error("new entry with wrong visit count");

    // One item at a time: stall right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

endmodule

bind visitor_table_lfu_unit vtl_checker u_vtl_checker (.*);

### tb/visit_tb_pkg.sv
// Result layout and table scoreboard for the visitor table unit testbench.
// Depends on vtl_pkg for field widths and count limits.
package visit_tb_pkg;

    import vtl_pkg::*;

    localparam int TABLE_ENTRIES = 32;

    // One result item as seen on the output channel
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               was_known;
        logic [COUNT_W-1:0] visits;
        logic               authorized;
        logic [TOTAL_W-1:0] total_requests;
    } visit_result_t;

    class visit_scoreboard;
        logic [ADDR_W-1:0]  addr_tab [TABLE_ENTRIES];
        logic [COUNT_W-1:0] count_tab[TABLE_ENTRIES];
        logic               auth_tab [TABLE_ENTRIES];
        logic [TOTAL_W-1:0] total;
        visit_result_t      expected_q[$];
        int                 errors;
        int                 checked;
        int                 hits;
        int                 evictions;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                addr_tab[i]  = '0;
                count_tab[i] = '0;
                auth_tab[i]  = 1'b0;
            end
            total     = '0;
            errors    = 0;
            checked   = 0;
            hits      = 0;
            evictions = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Look up or place the client, update its record and queue the result
        function void note_request(logic [ADDR_W-1:0] addr, logic counted, logic pass_ok);
            int            idx;
            int            empty_at;
            int            min_at;
            int unsigned   min_cnt;
            bit            found;
            bit            have_empty;
            visit_result_t r;
            found = 1'b0;
            idx   = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!found && count_tab[i] != '0 && addr_tab[i] == addr)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found)
            begin
                hits++;
            end
            else
            begin
                // prefer the highest empty entry, else the lowest least-count entry
                have_empty = 1'b0;
                empty_at   = 0;
                min_at     = 0;
                min_cnt    = 32'h1_0000;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (count_tab[i] == '0)
                    begin
                        have_empty = 1'b1;
                        empty_at   = i;
                    end
                    else if (count_tab[i] < min_cnt)
                    begin
                        min_cnt = count_tab[i];
                        min_at  = i;
                    end
                end
                if (have_empty)
                    idx = empty_at;
                else
                begin
                    idx = min_at;
                    evictions++;
                end
                addr_tab[idx]  = addr;
                count_tab[idx] = COUNT_ONE;
                auth_tab[idx]  = 1'b0;
            end
            // count the visit, holding both counters at their ceilings
            if (counted)
            begin
                if (count_tab[idx] != COUNT_MAX)
                    count_tab[idx] = count_tab[idx] + 1'b1;
                if (total != TOTAL_MAX)
                    total = total + 1'b1;
            end
            if (pass_ok)
                auth_tab[idx] = 1'b1;
            r.slot           = idx[SLOT_W-1:0];
            r.was_known      = found;
            r.visits         = count_tab[idx];
            r.authorized     = auth_tab[idx];
            r.total_requests = total;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare a result item with the oldest expectation, field by field
        task check_result(visit_result_t got);
            visit_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, slot %0d", got.slot));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.slot !== want.slot)
                report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                          checked, got.slot, want.slot));
            if (got.was_known !== want.was_known)
                report_mismatch($sformatf("result %0d was_known %0b, want %0b",
                                          checked, got.was_known, want.was_known));
            if (got.visits !== want.visits)
                report_mismatch($sformatf("result %0d visits %0d, want %0d",
                                          checked, got.visits, want.visits));
            if (got.authorized !== want.authorized)
                report_mismatch($sformatf("result %0d authorized %0b, want %0b",
                                          checked, got.authorized, want.authorized));
            if (got.total_requests !== want.total_requests)
                report_mismatch($sformatf("result %0d total_requests %0d, want %0d",
                                          checked, got.total_requests, want.total_requests));
        endtask
    endclass

endpackage

### tb/tb.sv
// Top-level testbench for visitor_table_lfu_unit: clock, reset, request driver and result monitor.
// Depends on vtl_pkg and visit_tb_pkg; the scoreboard predicts every result item.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vtl_pkg::*;
    import visit_tb_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 64;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [ADDR_W-1:0]  client_address;
    logic               counts_as_visit;
    logic               password_accepted;
    logic               out_valid;
    logic               out_stall;
    logic [SLOT_W-1:0]  slot;
    logic               was_known;
    logic [COUNT_W-1:0] visits;
    logic               authorized;
    logic [TOTAL_W-1:0] total_requests;

    visit_scoreboard    sb;
    bit                 idling_on;
    bit                 hold_req;
    int                 hold_left;
    logic [ADDR_W-1:0]  address_pool[POOL_SIZE];

    visitor_table_lfu_unit #(
        .ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .client_address   (client_address),
        .counts_as_visit  (counts_as_visit),
        .password_accepted(password_accepted),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .slot             (slot),
        .was_known        (was_known),
        .visits           (visits),
        .authorized       (authorized),
        .total_requests   (total_requests)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop in case the unit hangs
    initial
    begin
        #5_000_000;
        $display("visitor_table_lfu_unit regression: fail");
        $finish;
    end

    // Offer one request and hold it until accepted; idle before it at random
    task automatic send_request(logic [ADDR_W-1:0] addr, logic counted, logic pass_ok);
        int gap;
        gap = 0;
        while (idling_on && $urandom_range(99) < 16)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        client_address    <= addr;
        counts_as_visit   <= counted;
        password_accepted <= pass_ok;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(addr, counted, pass_ok);
    endtask

    // Drop valid and wait until every queued result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly clients from the pool, some fresh random addresses and the extremes
    function automatic logic [ADDR_W-1:0] pick_address(int pool_used);
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return $urandom();
        else if (sel == 8)
            return '0;
        else if (sel == 9)
            return '1;
        return address_pool[$urandom_range(pool_used - 1)];
    endfunction

    task automatic random_requests(int count, int pool_used, bit with_hold);
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 2)
                hold_req = 1'b1;
            send_request(pick_address(pool_used), $urandom_range(99) < 80,
                         $urandom_range(99) < 25);
        end
    endtask

    // Take results; stall at random, and hold off for a long stretch on request
    initial
    begin
        visit_result_t got;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.slot           = slot;
                got.was_known      = was_known;
                got.visits         = visits;
                got.authorized     = authorized;
                got.total_requests = total_requests;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idling_on && ($urandom_range(99) < 16);
        end
    end

    initial
    begin
        sb                = new();
        idling_on         = 1'b1;
        hold_req          = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        client_address    = '0;
        counts_as_visit   = 1'b0;
        password_accepted = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            address_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: address zero on an empty table, extremes, uncounted new entries, marks
        send_request('0,            1'b0, 1'b0);
        send_request('0,            1'b1, 1'b1);
        send_request('1,            1'b1, 1'b0);
        send_request('1,            1'b0, 1'b1);
        send_request(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_request(32'h5555_5555, 1'b1, 1'b1);
        send_request(32'h0000_0001, 1'b1, 1'b0);
        send_request(32'h8000_0000, 1'b1, 1'b0);
        send_request('0,            1'b0, 1'b0);
        send_request(32'hAAAA_AAAA, 1'b1, 1'b0);
        drain_results();

        // Small client set: mostly hits, long receiver hold part way through
        random_requests(250, 20, 1'b1);
        drain_results();

        // Large client set with no idling: table fills up and evicts
        idling_on = 1'b0;
        random_requests(200, POOL_SIZE, 1'b0);

        // Mid-sized client set with idling again
        idling_on = 1'b1;
        random_requests(330, 48, 1'b0);
        drain_results();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("Checked %0d results: %0d hits, %0d evictions, final total %0d.",
                 sb.checked, sb.hits, sb.evictions, sb.total);
        $display("Covered empty-table allocation, address extremes, marks and long output holds.");
        if (sb.errors == 0)
            $display("visitor_table_lfu_unit regression: pass");
        else
            $display("visitor_table_lfu_unit regression: fail");
        $finish;
    end

endmodule
